>>> hw/rtl/ppv_pkg.sv
// Shared types and constants of the perspective projection viewport block.
`timescale 1ns / 1ps
package ppv_pkg;

  // Field widths of the input and result words.
  localparam int unsigned COEF_W = 32;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned SCR_W  = 32;
  localparam int unsigned DIM_W  = 14;
  localparam int unsigned IDX_W  = 4;

  // Coefficient table size.
  localparam int unsigned NUM_COEF = 16;

  // Magnitude limit of the normalized device coordinates, in bits.
  localparam int unsigned NDC_LIMIT_BITS = 40;

  // Width of a clip coordinate sum and of the divider remainder.
  localparam int unsigned CLIP_W = 66;
  localparam int unsigned DIV_W  = 68;

  // Operation codes.
  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_PROJECT = 1'b1
  } op_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_e;

endpackage

>>> hw/rtl/ppv_if.sv
// Valid/ready channel interfaces for input and result words.
`timescale 1ns / 1ps
interface ppv_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [3:0]  coef_index;
  logic [31:0] coef_value;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;

  modport source (output valid, operation, coef_index, coef_value, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, operation, coef_index, coef_value, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface ppv_out_if;
  logic        valid;
  logic        ready;
  logic        visible;
  logic [31:0] screen_x;
  logic [31:0] screen_y;

  modport source (output valid, visible, screen_x, screen_y, input ready);
  modport sink (input valid, visible, screen_x, screen_y, output ready);
endinterface

>>> hw/rtl/perspective_projection_viewport.sv
// Top level of the world-to-screen projection pipeline.
//
// Usage: the input channel carries one word per item. A load word writes one
// signed coefficient of the 4x4 row-major view-projection table and gives no
// result. A project word multiplies the world point by table rows 0, 1 and 3,
// divides x and y by w and maps them to screen space; it gives one result word. The
// user must set screen width and height over the APB port only while idle (not enforced).
//
// Throughput is one word per cycle while the output is not stalled. A project
// word passes 45 register stages: one product stage, one clip sum stage, one
// divider setup stage, 40 restoring divider stages (one quotient bit each, set
// by the 40-bit limit of the normalized coordinate), one scale stage and the
// output register. A load word takes effect for every word accepted after it.
//
// Each stage holds its own valid bit and moves forward whenever the next stage
// is empty or moves too, so bubbles close up. A stalled receiver lets the
// pipeline keep filling, and input ready drops once all 45 stages hold a word.
// Reset clears all valid bits and sets the screen size to 1920 by 1080. The
// coefficient table has no reset and must be loaded before use.
`timescale 1ns / 1ps
module perspective_projection_viewport
  import ppv_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ppv_in_if.sink            in_i,
  ppv_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned NDIV    = NDC_LIMIT_BITS;
  localparam int unsigned NS      = NDIV + 5;
  localparam int unsigned SHIFT0  = NDC_LIMIT_BITS - FRAC_BITS;
  localparam int unsigned PROD_W  = 2 * COEF_W;
  localparam int unsigned MAG_W   = NDC_LIMIT_BITS + 1;
  localparam int unsigned K_W     = DIM_W + 1;
  localparam int unsigned SCALE_W = K_W + MAG_W + 1;
  localparam int unsigned SUM_W   = SCALE_W + 3;
  localparam logic signed [CLIP_W-1:0] W_MIN =
    CLIP_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sh7FFFFFFF);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sh80000000);

  typedef struct packed {
    logic              neg;
    logic              ovf;
    logic [CLIP_W-1:0] num;
    logic [DIV_W-1:0]  rem;
    logic [NDIV-1:0]   quo;
  } div_t;

  // Configuration registers.
  logic [DIM_W-1:0] width_q, height_q;
  logic             cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1920);
      height_q <= DIM_W'(1080);
    end else if (cfg_wr) begin
      unique case (cfg_e'(paddr[2]))
        CFG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        CFG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_e'(paddr[2]))
      CFG_WIDTH:  prdata = {(32 - DIM_W)'(0), width_q};
      CFG_HEIGHT: prdata = {(32 - DIM_W)'(0), height_q};
      default:    prdata = '0;
    endcase
  end

  // Stage valid bits and the backward ready chain.
  logic [NS:1]   valid_q;
  logic [NS+1:1] rdy;
  logic          in_acc;

  always_comb begin
    rdy[NS+1] = out_o.ready;
    for (int j = NS; j >= 1; j--) begin
      rdy[j] = !valid_q[j] || rdy[j+1];
    end
  end

  assign in_i.ready = rdy[1];
  assign in_acc     = in_i.valid && rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[1]) begin
        valid_q[1] <= in_i.valid && (op_e'(in_i.operation) == OP_PROJECT);
      end
      for (int j = 2; j <= NS; j++) begin
        if (rdy[j]) begin
          valid_q[j] <= valid_q[j-1];
        end
      end
    end
  end

  // Coefficient table, written by load words.
  logic [COEF_W-1:0] coef_q [NUM_COEF];

  always_ff @(posedge clk_i) begin
    if (in_acc && (op_e'(in_i.operation) == OP_LOAD)) begin
      coef_q[in_i.coef_index] <= in_i.coef_value;
    end
  end

  // Stage 1: the nine point products and the three translations.
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [COEF_W-1:0] trans_q [3];
  logic signed [CLIP_W-1:0] clip_q [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    localparam int unsigned BASE = (r == 2) ? 12 : 4 * r;
    logic signed [CLIP_W-1:0] clip_d;

    always_ff @(posedge clk_i) begin
      if (rdy[1]) begin
        prod_q[r][0] <= PROD_W'($signed(in_i.pos_x)) * PROD_W'($signed(coef_q[BASE]));
        prod_q[r][1] <= PROD_W'($signed(in_i.pos_y)) * PROD_W'($signed(coef_q[BASE + 1]));
        prod_q[r][2] <= PROD_W'($signed(in_i.pos_z)) * PROD_W'($signed(coef_q[BASE + 2]));
        trans_q[r]   <= $signed(coef_q[BASE + 3]);
      end
    end

    // Stage 2: floor each product to the fixed point and sum.
    always_comb begin
      clip_d = CLIP_W'(prod_q[r][0] >>> FRAC_BITS)
             + CLIP_W'(prod_q[r][1] >>> FRAC_BITS)
             + CLIP_W'(prod_q[r][2] >>> FRAC_BITS)
             + CLIP_W'(trans_q[r]);
    end

    always_ff @(posedge clk_i) begin
      if (rdy[2]) begin
        clip_q[r] <= clip_d;
      end
    end
  end

  // Stage 3 and the divider stages: index 0 holds the divider setup.
  div_t             dv_q  [NDIV+1][2];
  logic [DIV_W-1:0] den_q [NDIV+1];
  logic             vis_q [NDIV+1];

  logic [DIV_W-1:0] den_d;
  assign den_d = DIV_W'(unsigned'(clip_q[2]));

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      den_q[0] <= den_d;
      vis_q[0] <= (clip_q[2] >= W_MIN);
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_setup
    div_t             setup_d;
    logic [CLIP_W-1:0] mag;

    always_comb begin
      mag           = clip_q[c][CLIP_W-1] ? -unsigned'(clip_q[c]) : unsigned'(clip_q[c]);
      setup_d.neg   = clip_q[c][CLIP_W-1];
      setup_d.num   = mag;
      setup_d.rem   = DIV_W'(mag >> SHIFT0);
      setup_d.ovf   = setup_d.rem >= den_d;
      setup_d.quo   = '0;
    end

    always_ff @(posedge clk_i) begin
      if (rdy[3]) begin
        dv_q[0][c] <= setup_d;
      end
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    localparam int unsigned BIT = NDIV - 1 - k;

    always_ff @(posedge clk_i) begin
      if (rdy[4 + k]) begin
        den_q[k+1] <= den_q[k];
        vis_q[k+1] <= vis_q[k];
      end
    end

    for (genvar c = 0; c < 2; c++) begin : g_ch
      logic             nb;
      logic [DIV_W-1:0] trial;
      logic             ge;
      div_t             step_d;

      if (BIT >= FRAC_BITS) begin : g_bit
        assign nb = dv_q[k][c].num[BIT - FRAC_BITS];
      end else begin : g_zero
        assign nb = 1'b0;
      end

      always_comb begin
        trial      = {dv_q[k][c].rem[DIV_W-2:0], nb};
        ge         = trial >= den_q[k];
        step_d     = dv_q[k][c];
        step_d.rem = ge ? trial - den_q[k] : trial;
        step_d.quo = {dv_q[k][c].quo[NDIV-2:0], ge};
      end

      always_ff @(posedge clk_i) begin
        if (rdy[4 + k]) begin
          dv_q[k+1][c] <= step_d;
        end
      end
    end
  end

  // Scale stage: multiply the quotient magnitude by the screen factors.
  logic [DIM_W-2:0]          hw, hh;
  logic signed [K_W-1:0]     kx, ky;
  logic signed [SCALE_W-1:0] scale_q [2];
  logic                      sneg_q [2];
  logic                      svis_q;

  assign hw = width_q[DIM_W-1:1];
  assign hh = height_q[DIM_W-1:1];
  assign kx = $signed({2'b00, hw}) + K_W'(1);
  assign ky = K_W'(1) - $signed({2'b00, hh});

  for (genvar c = 0; c < 2; c++) begin : g_scale
    logic [MAG_W-1:0] mag;
    logic signed [K_W-1:0] kf;

    assign mag = dv_q[NDIV][c].ovf ? MAG_W'(1) << NDC_LIMIT_BITS
                                   : {1'b0, dv_q[NDIV][c].quo};
    assign kf  = (c == 0) ? kx : ky;

    always_ff @(posedge clk_i) begin
      if (rdy[NS-1]) begin
        scale_q[c] <= SCALE_W'(kf) * $signed(SCALE_W'({1'b0, mag}));
        sneg_q[c]  <= dv_q[NDIV][c].neg;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      svis_q <= vis_q[NDIV];
    end
  end

  // Output stage: apply the sign, add the screen center and saturate; hidden points give zero.
  logic [SCR_W-1:0] scr_d [2];
  logic [SCR_W-1:0] scr_q [2];
  logic             ovis_q;

  for (genvar c = 0; c < 2; c++) begin : g_out
    logic signed [SUM_W-1:0] sum;
    logic [DIM_W-2:0]        half;

    assign half = (c == 0) ? hw : hh;

    always_comb begin
      sum = (sneg_q[c] ? -SUM_W'(scale_q[c]) : SUM_W'(scale_q[c]))
          + (SUM_W'(half) << FRAC_BITS);
      priority if (!svis_q) begin
        scr_d[c] = '0;
      end else if (sum > SAT_MAX) begin
        scr_d[c] = SAT_MAX[SCR_W-1:0];
      end else if (sum < SAT_MIN) begin
        scr_d[c] = SAT_MIN[SCR_W-1:0];
      end else begin
        scr_d[c] = sum[SCR_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[NS]) begin
        scr_q[c] <= scr_d[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS]) begin
      ovis_q <= svis_q;
    end
  end

  assign out_o.valid    = valid_q[NS];
  assign out_o.visible  = ovis_q;
  assign out_o.screen_x = scr_q[0];
  assign out_o.screen_y = scr_q[1];

endmodule

>>> hw/rtl/ppv_checker.sv
// Port-level assertions for the projection pipeline and their bind.
`timescale 1ns / 1ps
module ppv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        visible_i,
  input logic [31:0] screen_x_i,
  input logic [31:0] screen_y_i,
  input logic        pready_i
);

  // A stalled result word holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(visible_i)
      && $stable(screen_x_i) && $stable(screen_y_i))
    else $error("stalled result word changed");

  // A point behind the near limit reports zero coordinates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !visible_i |-> screen_x_i == '0 && screen_y_i == '0)
    else $error("hidden point has nonzero coordinates");

  // Input back-pressure only comes from a full pipeline behind a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // The configuration port never inserts wait states.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("pready dropped");

endmodule

bind perspective_projection_viewport ppv_checker u_ppv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .visible_i   (out_o.visible),
  .screen_x_i  (out_o.screen_x),
  .screen_y_i  (out_o.screen_y),
  .pready_i    (pready)
);
